// ===== rtl/button_press_classifier_top_macros.svh =====
// Assertion macros used by the button press classifier top level.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle.
`define BPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Types and constants of the button press classifier.
package bpc_pkg;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_event_t;

  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd2;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] DOUBLE_GAP_RESET = 16'd300;

  typedef struct packed {
    logic [15:0] long_press_time;
    logic [15:0] debounce_time;
    logic [15:0] double_gap_time;
  } bpc_cfg_t;

  typedef struct packed {
    logic held_flag;
    logic click_pending;
    logic await_release;
  } bpc_status_t;

endpackage

// ===== rtl/bpc_core.sv =====
// Press classification state and the per-sample decision logic.
module bpc_core
  import bpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic         button_down,
  input  logic [31:0]  time_ms,
  input  bpc_cfg_t     cfg,
  output press_event_t press_event,
  output bpc_status_t  status
);

  logic        held_flag, held_flag_next;
  logic        click_pending, click_pending_next;
  logic        await_release, await_release_next;
  logic [31:0] press_begin, press_begin_next;
  logic [31:0] release_stamp, release_stamp_next;

  logic [31:0] press_age;
  logic [31:0] release_age;

  assign press_age   = time_ms - press_begin;
  assign release_age = time_ms - release_stamp;

  always_comb begin
    held_flag_next     = held_flag;
    click_pending_next = click_pending;
    await_release_next = await_release;
    press_begin_next   = press_begin;
    release_stamp_next = release_stamp;
    press_event        = EV_NONE;

    if (await_release && button_down) begin
      // Long code already given: ignore the rest of the hold.
      press_event = EV_NONE;
    end else begin
      await_release_next = 1'b0;
      if (button_down && !held_flag) begin
        press_begin_next = time_ms;
        held_flag_next   = 1'b1;
      end else if (button_down) begin
        if (press_age >= {16'd0, cfg.long_press_time}) begin
          held_flag_next     = 1'b0;
          click_pending_next = 1'b0;
          await_release_next = 1'b1;
          press_event        = EV_LONG;
        end
      end else if (held_flag) begin
        held_flag_next = 1'b0;
        if (press_age >= {16'd0, cfg.debounce_time} &&
            press_age < {16'd0, cfg.long_press_time}) begin
          if (click_pending && release_age < {16'd0, cfg.double_gap_time}) begin
            click_pending_next = 1'b0;
            press_event        = EV_DOUBLE;
          end else begin
            click_pending_next = 1'b1;
            release_stamp_next = time_ms;
          end
        end
      end else if (click_pending && release_age >= {16'd0, cfg.double_gap_time}) begin
        click_pending_next = 1'b0;
        press_event        = EV_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag     <= 1'b0;
      click_pending <= 1'b0;
      await_release <= 1'b0;
      press_begin   <= '0;
      release_stamp <= '0;
    end else if (fire) begin
      held_flag     <= held_flag_next;
      click_pending <= click_pending_next;
      await_release <= await_release_next;
      press_begin   <= press_begin_next;
      release_stamp <= release_stamp_next;
    end
  end

  assign status = '{held_flag: held_flag, click_pending: click_pending,
                    await_release: await_release};

endmodule

// ===== rtl/button_press_classifier_top.sv =====
// Top level of the button press classifier: stream ports, registers, pipeline.
//
//   channel  direction  word contents
//   s_*      in         button_down, time_ms
//   m_*      out        press_event
//   cfg_*    in         register index and 16-bit value
//
// One word in, one word out, one word per cycle sustained while the output is not
// stalled; each word passes the input register, then the classifier, then the
// result register. Synchronous active-high reset clears the press state and loads
// the register defaults. A stalled output holds the result register; the input
// register takes a word only if it is empty, then the input side stalls too.
module button_press_classifier_top
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] button_down, [32:1] time_ms, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] press_event, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "button_press_classifier_top_macros.svh"

  bpc_cfg_t     cfg;
  bpc_status_t  status;
  press_event_t core_event;

  logic        in_valid;
  logic        in_down;
  logic [31:0] in_time;
  logic [1:0]  out_event;
  logic        fire;

  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_time <= LONG_PRESS_RESET;
      cfg.debounce_time   <= DEBOUNCE_RESET;
      cfg.double_gap_time <= DOUBLE_GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LONG_PRESS: cfg.long_press_time <= cfg_data;
        REG_DEBOUNCE:   cfg.debounce_time   <= cfg_data;
        REG_DOUBLE_GAP: cfg.double_gap_time <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_down <= s_tdata[0];
      in_time <= s_tdata[32:1];
    end
  end

  bpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .button_down (in_down),
    .time_ms     (in_time),
    .cfg         (cfg),
    .press_event (core_event),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event <= core_event;
    end
  end

  assign m_tdata = {6'd0, out_event};

  `BPC_ASSERT_NOW(a_await_not_held, clk, rst, status.await_release, !status.held_flag, "await_release with a press still counted")
  `BPC_ASSERT_NEXT(a_long_sets_await, clk, rst, fire && core_event == EV_LONG, status.await_release && !status.click_pending, "long code without wait for release")
  `BPC_ASSERT_NEXT(a_double_clears_click, clk, rst, fire && core_event == EV_DOUBLE, !status.click_pending, "double code left a click pending")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the button press classifier: directed table, then random press runs.
module tb;
  import bpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index beyond the three registers: writes to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_OFF_CYCLES = 60;

  typedef struct {
    bit           is_reg;
    logic [1:0]   reg_idx;
    logic [15:0]  reg_val;
    bit           down;
    logic [31:0]  stamp;
    bit           typed;
    press_event_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Shadow copy of the classifier registers and press state.
  logic [15:0] long_limit;
  logic [15:0] bounce_limit;
  logic [15:0] gap_limit;
  bit          is_held;
  logic [31:0] held_since;
  logic [31:0] last_click;
  bit          click_waiting;
  bit          long_given;

  press_event_t pending_events[$];
  stim_row_t    stim_rows[$];
  int           fail_count;
  bit           burst;
  bit           hold_req;

  button_press_classifier_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic press_event_t classify_sample(input bit down, input logic [31:0] now);
    logic [31:0] held_for;
    if (long_given) begin
      if (down) return EV_NONE;
      long_given = 1'b0;
    end
    if (down && !is_held) begin
      held_since = now;
      is_held = 1'b1;
      return EV_NONE;
    end
    if (down) begin
      if (now - held_since >= {16'd0, long_limit}) begin
        is_held = 1'b0;
        click_waiting = 1'b0;
        long_given = 1'b1;
        return EV_LONG;
      end
      return EV_NONE;
    end
    if (is_held) begin
      held_for = now - held_since;
      is_held = 1'b0;
      if (held_for < {16'd0, bounce_limit}) return EV_NONE;
      if (held_for < {16'd0, long_limit}) begin
        if (click_waiting && (now - last_click < {16'd0, gap_limit})) begin
          click_waiting = 1'b0;
          return EV_DOUBLE;
        end
        click_waiting = 1'b1;
        last_click = now;
      end
      return EV_NONE;
    end
    if (click_waiting && (now - last_click >= {16'd0, gap_limit})) begin
      click_waiting = 1'b0;
      return EV_SINGLE;
    end
    return EV_NONE;
  endfunction

  task automatic row_sample(input bit down, input logic [31:0] stamp, input bit typed,
                            input press_event_t want);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = REG_LONG_PRESS;
    r.reg_val = '0;
    r.down = down;
    r.stamp = stamp;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endtask

  task automatic row_reg(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t r;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.down = 1'b0;
    r.stamp = '0;
    r.typed = 1'b0;
    r.want = EV_NONE;
    stim_rows.push_back(r);
  endtask

  // Offer one sample word after a random gap, none in burst mode; the expectation is queued on acceptance.
  task automatic send_sample(input bit down, input logic [31:0] stamp, input bit typed,
                             input press_event_t want);
    int gap;
    int r;
    press_event_t got;
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, stamp, down};
    do @(posedge clk); while (!s_tready);
    got = classify_sample(down, stamp);
    pending_events.push_back(typed ? want : got);
  endtask

  // Stop offering and wait until every result is back, then let the pipeline settle.
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LONG_PRESS: long_limit = val;
      REG_DEBOUNCE:   bounce_limit = val;
      REG_DOUBLE_GAP: gap_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, occasional long ones, and one forced hold-off on request.
  initial begin
    int stall;
    int r;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (burst) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    press_event_t exp_ev;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result word, press_event %0d", $time, m_tdata[1:0]);
        fail_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (press_event_t'(m_tdata[1:0]) !== exp_ev) begin
          $display("%0t: press_event mismatch, expected %s got %0d",
                   $time, exp_ev.name(), m_tdata[1:0]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [31:0] now;
    logic [15:0] scale;
    bit          down;
    int          run_left;
    int          r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LONG_PRESS;
    cfg_data = '0;
    fail_count = 0;
    burst = 1'b0;
    hold_req = 1'b0;
    long_limit = LONG_PRESS_RESET;
    bounce_limit = DEBOUNCE_RESET;
    gap_limit = DOUBLE_GAP_RESET;
    is_held = 1'b0;
    held_since = '0;
    last_click = '0;
    click_waiting = 1'b0;
    long_given = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: long 1000, debounce 50, gap 300.
    row_sample(1'b0, 32'd0,    1'b1, EV_NONE);
    row_sample(1'b1, 32'd100,  1'b1, EV_NONE);
    row_sample(1'b1, 32'd1100, 1'b1, EV_LONG);
    row_sample(1'b1, 32'd1200, 1'b1, EV_NONE);
    row_sample(1'b0, 32'd1300, 1'b1, EV_NONE);
    // Bounce, then a lone click that times out into a single, then a double click.
    row_sample(1'b1, 32'd2000, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd2010, 1'b1, EV_NONE);
    row_sample(1'b1, 32'd2100, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd2200, 1'b1, EV_NONE);
    row_sample(1'b0, 32'd2600, 1'b1, EV_SINGLE);
    row_sample(1'b1, 32'd3000, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd3100, 1'b0, EV_NONE);
    row_sample(1'b1, 32'd3200, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd3300, 1'b1, EV_DOUBLE);
    // Released after the long time with no sample in between: no code.
    row_sample(1'b1, 32'd4000, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd5500, 1'b1, EV_NONE);
    // Press across the wrap of the timestamp.
    row_sample(1'b1, 32'hFFFF_FF00, 1'b0, EV_NONE);
    row_sample(1'b0, 32'h0000_0010, 1'b0, EV_NONE);
    row_sample(1'b0, 32'h0000_0200, 1'b1, EV_SINGLE);
    row_reg(REG_LONG_PRESS, 16'd0);
    row_reg(REG_DEBOUNCE, 16'hFFFF);
    row_reg(REG_DOUBLE_GAP, 16'hFFFF);
    row_reg(REG_SPARE, 16'h1234);
    row_sample(1'b1, 32'hFFFF_FFFF, 1'b1, EV_NONE);
    row_sample(1'b1, 32'hFFFF_FFFF, 1'b1, EV_LONG);
    row_sample(1'b0, 32'd0,         1'b1, EV_NONE);
    row_reg(REG_LONG_PRESS, 16'hFFFF);
    row_reg(REG_DEBOUNCE, 16'd0);
    row_sample(1'b1, 32'd5, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd5, 1'b0, EV_NONE);
    row_sample(1'b1, 32'd6, 1'b0, EV_NONE);
    row_sample(1'b0, 32'd7, 1'b1, EV_DOUBLE);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        drain();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_sample(stim_rows[i].down, stim_rows[i].stamp, stim_rows[i].typed,
                    stim_rows[i].want);
      end
    end

    now = $urandom;
    down = 1'b0;
    run_left = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_LONG_PRESS, LONG_PRESS_RESET);
          write_reg(REG_DEBOUNCE, DEBOUNCE_RESET);
          write_reg(REG_DOUBLE_GAP, DOUBLE_GAP_RESET);
        end
        1: begin
          write_reg(REG_LONG_PRESS, 16'd40);
          write_reg(REG_DEBOUNCE, 16'd5);
          write_reg(REG_DOUBLE_GAP, 16'd30);
        end
        2: begin
          write_reg(REG_LONG_PRESS, 16'd0);
          write_reg(REG_DEBOUNCE, 16'd0);
          write_reg(REG_DOUBLE_GAP, 16'd0);
        end
        3: begin
          write_reg(REG_LONG_PRESS, 16'hFFFF);
          write_reg(REG_DEBOUNCE, 16'hFFFF);
          write_reg(REG_DOUBLE_GAP, 16'hFFFF);
        end
        4: begin
          write_reg(REG_DOUBLE_GAP, 16'd120);
          write_reg(REG_DEBOUNCE, 16'd20);
          write_reg(REG_LONG_PRESS, 16'd200);
        end
        default: begin
          write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 100)));
          write_reg(REG_DOUBLE_GAP, 16'($urandom_range(0, 400)));
          write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 1500)));
        end
      endcase
      write_reg(REG_SPARE, 16'($urandom));

      for (int i = 0; i < 120; i++) begin
        burst = (i >= 80 && i < 110);
        if (ph == 1 && i == 30) hold_req = 1'b1;
        // The sender goes quiet until every outstanding result has come back.
        if (ph == 3 && i == 60) drain();
        // Press and release runs of a few samples, with some level noise.
        if (run_left == 0) begin
          down = !down;
          run_left = down ? $urandom_range(1, 4) : $urandom_range(1, 5);
        end
        run_left--;
        if ($urandom_range(0, 9) == 0) down = 1'($urandom);
        r = $urandom_range(0, 19);
        case (r)
          0: now = $urandom;
          1: now = now - $urandom_range(1, 500);
          2: ;
          default: begin
            case ($urandom_range(0, 2))
              0: scale = long_limit;
              1: scale = bounce_limit;
              default: scale = gap_limit;
            endcase
            now = now + $urandom_range(0, {16'd0, scale} + scale / 2 + 2);
          end
        endcase
        send_sample(down, now, 1'b0, EV_NONE);
      end
    end
    burst = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_core.sv
rtl/button_press_classifier_top.sv
verif/tb.sv
